[hw/rtl/orpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orpd_pkg
// Shared types, constants and arithmetic helpers of the 3x3 outlier filter.
// ----------------------------------------------------------------------------
package orpd_pkg;

  localparam int LineDepth = 2048;
  localparam int AddrW     = $clog2(LineDepth);
  localparam int ColW      = 11;
  localparam int RowW      = 16;
  localparam int WidthW    = 12;
  localparam int PixW      = 24;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

  localparam logic [WidthW-1:0] WidthReset  = 12'd640;
  localparam logic [RowW-1:0]   HeightReset = 16'd480;

  // Bookkeeping that travels with each pixel through the pipeline.
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            inner;
    logic            emit_a;   // pixel (row-1, col-1)
    logic            emit_b;   // pixel (row-1, col), end of row
    logic            emit_c;   // pixel (row, col), last row
  } desc_t;

  typedef struct packed {
    desc_t           desc;
    logic [PixW-1:0] center;
    logic [PixW-1:0] right;
    logic [PixW-1:0] cur;
    logic [PixW-1:0] mean;
  } pass_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [PixW-1:0] px;
    logic            rep;
    logic            last;
  } result_t;

  // floor(x/3) for x <= 765 by reciprocal multiply.
  function automatic logic [7:0] gray3(input logic [9:0] x);
    logic [18:0] prod;
    prod = 19'(x) * 19'd683;
    return prod[18:11];
  endfunction

  // floor(x/24) for x <= 6120 by reciprocal multiply.
  function automatic logic [7:0] div24(input logic [12:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'd2731;
    return prod[23:16];
  endfunction

endpackage

[hw/rtl/orpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orpd_front
// Frame registers, raster counters and the two line buffers.
// ----------------------------------------------------------------------------
module orpd_front import orpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                accept_i,
  input  logic                adv_i,
  input  logic [PixW-1:0]     pix_i,
  output logic                valid_o,
  output desc_t               desc_o,
  output logic [PixW-1:0]     cur_o,
  output logic [PixW-1:0]     up_o,
  output logic [PixW-1:0]     mid_o
);

  logic [WidthW-1:0] width_q;
  logic [RowW-1:0]   height_q;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [WidthW-1:0] w_eff;
  logic [RowW-1:0]   h_eff;
  logic              wrap_c;
  logic [ColW-1:0]   c0;
  logic [RowW:0]     r0x, r1x;
  logic [RowW-1:0]   r0;
  logic [WidthW-1:0] c1;
  desc_t             desc_d;

  logic [PixW-1:0]   upper_mem [LineDepth];
  logic [PixW-1:0]   middle_mem [LineDepth];
  logic [PixW-1:0]   up_rd_q, mid_rd_q;
  logic              pend_q;
  logic [AddrW-1:0]  pend_addr_q;
  logic [AddrW-1:0]  addr;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (width_q > WidthW'(LineDepth)) begin
      w_eff = WidthW'(LineDepth);
    end else begin
      w_eff = width_q;
    end
    h_eff  = (height_q == '0) ? RowW'(1) : height_q;
    wrap_c = {1'b0, col_q} >= w_eff;
    c0     = wrap_c ? '0 : col_q;
    r0x    = wrap_c ? ({1'b0, row_q} + 17'd1) : {1'b0, row_q};
    r0     = (r0x >= {1'b0, h_eff}) ? '0 : r0x[RowW-1:0];
    c1     = {1'b0, c0} + WidthW'(1);
    r1x    = {1'b0, r0} + 17'd1;
    if (c1 >= w_eff) begin
      col_d = '0;
      row_d = (r1x >= {1'b0, h_eff}) ? '0 : r1x[RowW-1:0];
    end else begin
      col_d = c1[ColW-1:0];
      row_d = r0;
    end
    desc_d.row    = r0;
    desc_d.col    = c0;
    desc_d.inner  = (r0 >= RowW'(2)) && (c0 >= ColW'(2));
    desc_d.emit_a = (r0 != '0) && (c0 != '0);
    desc_d.emit_b = (r0 != '0) && (c1 == w_eff);
    desc_d.emit_c = (r1x == {1'b0, h_eff});
    addr          = c0[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      valid_o  <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegFrameWidth) begin
        width_q <= cfg_wdata_i[WidthW-1:0];
      end
      if (cfg_we_i && cfg_idx_i == RegFrameHeight) begin
        height_q <= cfg_wdata_i[RowW-1:0];
      end
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (adv_i) begin
        valid_o <= accept_i;
      end
      pend_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      desc_o <= desc_d;
      cur_o  <= pix_i;
    end
  end

  // The upper line takes the old middle entry in the cycle after the read; a
  // read of that same entry in the meantime is served from the read register.
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      upper_mem[pend_addr_q] <= mid_rd_q;
    end
    if (accept_i) begin
      up_rd_q     <= (pend_q && pend_addr_q == addr) ? mid_rd_q : upper_mem[addr];
      mid_rd_q    <= middle_mem[addr];
      middle_mem[addr] <= pix_i;
      pend_addr_q <= addr;
    end
  end

  assign up_o  = up_rd_q;
  assign mid_o = mid_rd_q;

endmodule

[hw/rtl/orpd_kernel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orpd_kernel
// 3x3 window and the pipelined outlier test and neighbor mean.
// ----------------------------------------------------------------------------
module orpd_kernel import orpd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  desc_t           desc_i,
  input  logic [PixW-1:0] cur_i,
  input  logic [PixW-1:0] up_i,
  input  logic [PixW-1:0] mid_i,
  output logic            valid_o,
  output pass_t           pass_o,
  output logic            rep_o
);

  logic [PixW-1:0] win_q [9];
  desc_t           desc2_q;
  logic [6:2]      v_q;

  // Stage 3: channel sums and gray values.
  logic [10:0]     sum_d [3];
  logic [10:0]     sum_q [3];
  logic [7:0]      gray_d [9];
  logic [7:0]      gray_q [9];
  pass_t           p3_d, p3_q;

  // Stage 4: deviations from the neighbor sum.
  logic [12:0]        s_all;
  logic signed [13:0] dev_d [9];
  logic signed [13:0] dev_q [9];
  pass_t              p4_d, p4_q;

  // Stage 5: squares and scaled center deviation.
  logic [12:0] mag [9];
  logic [25:0] sq_d [9];
  logic [25:0] sq_q [9];
  logic [7:0]  e_q;
  pass_t       p5_q;

  // Stage 6: accumulated energy and squared center term.
  logic [28:0] acc_d, acc_q;
  logic [15:0] esq_q;
  pass_t       p6_q;

  logic [29:0] lhs;

  always_comb begin
    sum_d[0] = '0;
    sum_d[1] = '0;
    sum_d[2] = '0;
    for (int i = 0; i < 9; i++) begin
      gray_d[i] = gray3(10'(win_q[i][23:16]) + 10'(win_q[i][15:8]) + 10'(win_q[i][7:0]));
      if (i != 4) begin
        sum_d[0] = sum_d[0] + 11'(win_q[i][23:16]);
        sum_d[1] = sum_d[1] + 11'(win_q[i][15:8]);
        sum_d[2] = sum_d[2] + 11'(win_q[i][7:0]);
      end
    end
    p3_d.desc   = desc2_q;
    p3_d.center = win_q[4];
    p3_d.right  = win_q[5];
    p3_d.cur    = win_q[8];
    p3_d.mean   = '0;
  end

  always_comb begin
    s_all = 13'(sum_q[0]) + 13'(sum_q[1]) + 13'(sum_q[2]);
    for (int i = 0; i < 9; i++) begin
      dev_d[i] = $signed({1'b0, 13'(gray_q[i]) * 13'd24}) - $signed({1'b0, s_all});
    end
    p4_d      = p3_q;
    p4_d.mean = {sum_q[0][10:3], sum_q[1][10:3], sum_q[2][10:3]};
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mag[i]  = dev_q[i][13] ? 13'(-dev_q[i]) : dev_q[i][12:0];
      sq_d[i] = 26'(mag[i]) * 26'(mag[i]);
    end
  end

  always_comb begin
    acc_d = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        acc_d = acc_d + 29'(sq_q[i]);
      end
    end
  end

  assign lhs = 30'(esq_q) * 30'd4608;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      v_q     <= '0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      if (valid_i) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i*3]   <= win_q[i*3+1];
          win_q[i*3+1] <= win_q[i*3+2];
        end
        win_q[2] <= up_i;
        win_q[5] <= mid_i;
        win_q[8] <= cur_i;
      end
      v_q     <= {v_q[5:2], valid_i};
      valid_o <= v_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      desc2_q <= desc_i;
      sum_q   <= sum_d;
      gray_q  <= gray_d;
      p3_q    <= p3_d;
      dev_q   <= dev_d;
      p4_q    <= p4_d;
      sq_q    <= sq_d;
      e_q     <= div24(mag[4]);
      p5_q    <= p4_q;
      acc_q   <= acc_d;
      esq_q   <= 16'(e_q) * 16'(e_q);
      p6_q    <= p5_q;
      pass_o  <= p6_q;
      rep_o   <= p6_q.desc.inner && (lhs > 30'(acc_q));
    end
  end

endmodule

[hw/rtl/orpd_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orpd_outq
// Holds the up to three results of one item and hands them out in order.
// ----------------------------------------------------------------------------
module orpd_outq import orpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  pass_t   pass_i,
  input  logic    rep_i,
  output logic    adv_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_res_o
);

  result_t    slot_q [3];
  result_t    slot_d [3];
  logic [2:0] mask_q, mask_d, emit;
  logic [2:0] head;

  always_comb begin
    emit = valid_i ? {pass_i.desc.emit_c, pass_i.desc.emit_b, pass_i.desc.emit_a} : 3'b000;

    slot_d[0].row  = pass_i.desc.row - RowW'(1);
    slot_d[0].col  = pass_i.desc.col - ColW'(1);
    slot_d[0].px   = rep_i ? pass_i.mean : pass_i.center;
    slot_d[0].rep  = rep_i;
    slot_d[0].last = !emit[1] && !emit[2];
    slot_d[1].row  = pass_i.desc.row - RowW'(1);
    slot_d[1].col  = pass_i.desc.col;
    slot_d[1].px   = pass_i.right;
    slot_d[1].rep  = 1'b0;
    slot_d[1].last = !emit[2];
    slot_d[2].row  = pass_i.desc.row;
    slot_d[2].col  = pass_i.desc.col;
    slot_d[2].px   = pass_i.cur;
    slot_d[2].rep  = 1'b0;
    slot_d[2].last = 1'b1;

    head = mask_q & (~mask_q + 3'd1);
    unique case (1'b1)
      head[0]: m_res_o = slot_q[0];
      head[1]: m_res_o = slot_q[1];
      head[2]: m_res_o = slot_q[2];
      default: m_res_o = slot_q[0];
    endcase

    m_valid_o = |mask_q;
    // The pipeline moves when the queue is empty after this cycle.
    adv_o  = (mask_q == '0) || ($onehot(mask_q) && m_ready_i);
    mask_d = (m_valid_o && m_ready_i) ? (mask_q & ~head) : mask_q;
    if (adv_o) begin
      mask_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      slot_q <= slot_d;
    end
  end

endmodule

[hw/rtl/outlier_replace_denoise_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outlier_replace_denoise_3x3
// 3x3 outlier-replacing denoise filter on an RGB raster stream.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: red, green, blue (8 bit each)
//  m_axis    out        tdata: row, col, red, green, blue; tuser: replaced;
//                       tlast: last result of an item
//  cfg       in         write enable, index, data (width, height)
//
// One item per cycle is taken while the output queue lets the pipeline move;
// an item passes eight register stages before its first result is offered.
// An item that yields two or three results holds the input while the output
// queue drains, one result per cycle while m_axis is ready.
// Reset clears counters, window and queue; line buffers need no clearing.
// A stall at the output freezes the whole pipeline in place.
module outlier_replace_denoise_3x3 import orpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // red, green, blue
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [55:0]         m_axis_tdata,  // row, col, red, green, blue, zero fill
  output logic                m_axis_tuser,  // was_replaced
  output logic                m_axis_tlast
);

  logic            adv, accept;
  logic            v1, vk;
  desc_t           desc1;
  logic [PixW-1:0] cur1, up1, mid1, pix_in;
  pass_t           passk;
  logic            repk;
  result_t         res;

  assign accept = s_axis_tvalid && adv;
  assign s_axis_tready = adv;
  assign pix_in = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  orpd_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .accept_i(accept), .adv_i(adv), .pix_i(pix_in),
    .valid_o(v1), .desc_o(desc1), .cur_o(cur1), .up_o(up1), .mid_o(mid1)
  );

  orpd_kernel u_kernel (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v1), .desc_i(desc1),
    .cur_i(cur1), .up_i(up1), .mid_i(mid1),
    .valid_o(vk), .pass_o(passk), .rep_o(repk)
  );

  orpd_outq u_outq (
    .clk_i, .rst_ni, .valid_i(vk), .pass_i(passk), .rep_i(repk),
    .adv_o(adv), .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_res_o(res)
  );

  assign m_axis_tdata = {5'd0, res.px[7:0], res.px[15:8], res.px[23:16], res.col, res.row};
  assign m_axis_tuser = res.rep;
  assign m_axis_tlast = res.last;

endmodule

[hw/rtl/orpd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orpd_checker
// Port-level checks of the denoise filter, bound to the top level.
// ----------------------------------------------------------------------------
module orpd_checker import orpd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A waiting result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Replaced pixels never lie in the first row or the first column.
  a_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[15:0] != 16'd0) && (m_axis_tdata[26:16] != 11'd0))
    else $error("border pixel marked replaced");

  // An empty output queue never holds back the input.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind outlier_replace_denoise_3x3 orpd_checker u_orpd_checker (
  .clk_i, .rst_ni, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 outlier-replacing denoise filter. A
// behavioral model of the line buffers, window and outlier test predicts
// every output pixel with its coordinates. The stimulus is frames of several
// sizes, some unfinished, mostly smooth images with spikes, stalled or not.
// ----------------------------------------------------------------------------

class denoise_scoreboard;
  typedef struct {
    logic [15:0] row;
    logic [10:0] col;
    logic [23:0] px;
    logic        rep;
    logic        last;
  } out_pixel_t;

  logic [23:0] upper_line [2048];
  logic [23:0] middle_line [2048];
  logic [23:0] win [9];
  int unsigned width_reg, height_reg, row_cnt, col_cnt;
  out_pixel_t  pending_pixels [$];
  int          mismatches, checked, replaced_seen;

  function new();
    width_reg = 640;
    height_reg = 480;
    row_cnt = 0;
    col_cnt = 0;
    mismatches = 0;
    checked = 0;
    replaced_seen = 0;
    foreach (win[i]) win[i] = '0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == orpd_pkg::RegFrameWidth) width_reg = val[11:0];
    else if (idx == orpd_pkg::RegFrameHeight) height_reg = val;
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction

  function int gray(logic [23:0] p);
    return (int'(p[23:16]) + int'(p[15:8]) + int'(p[7:0])) / 3;
  endfunction

  // Outlier test on the window center; returns 1 and the mean when replaced.
  function logic filter_center(output logic [23:0] res);
    int     sr, sg, sb;
    longint s, acc, d, e;
    sr = 0; sg = 0; sb = 0; acc = 0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        sr += win[i][23:16];
        sg += win[i][15:8];
        sb += win[i][7:0];
      end
    end
    s = sr + sg + sb;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        d = 24 * gray(win[i]) - s;
        acc += d * d;
      end
    end
    d = 24 * gray(win[4]) - s;
    if (d < 0) d = -d;
    e = d / 24;
    if (4608 * e * e > acc) begin
      res = {8'(sr / 8), 8'(sg / 8), 8'(sb / 8)};
      return 1'b1;
    end
    res = win[4];
    return 1'b0;
  endfunction

  function void push_pixel(int unsigned r, int unsigned c, logic [23:0] p, logic rep);
    out_pixel_t o;
    o.row = r[15:0];
    o.col = c[10:0];
    o.px = p;
    o.rep = rep;
    o.last = 1'b0;
    pending_pixels.push_back(o);
  endfunction

  // Notes an accepted input pixel, {red, green, blue}, and predicts its results.
  function void note_pixel(logic [23:0] cur);
    int unsigned w, h, r, c, n;
    logic [23:0] p;
    logic        rep;
    w = width_reg;
    h = height_reg;
    n = 0;
    if (w == 0) w = 1;
    if (w > 2048) w = 2048;
    if (h == 0) h = 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = upper_line[c];
    win[5] = middle_line[c];
    win[8] = cur;
    upper_line[c] = middle_line[c];
    middle_line[c] = cur;
    if (r >= 1) begin
      if (c >= 1) begin
        if (r - 1 >= 1 && r + 1 <= h && c - 1 >= 1 && c + 1 <= w) begin
          rep = filter_center(p);
        end else begin
          p = win[4];
          rep = 1'b0;
        end
        push_pixel(r - 1, c - 1, p, rep);
        n++;
      end
      if (c + 1 == w) begin
        push_pixel(r - 1, c, win[5], 1'b0);
        n++;
      end
    end
    if (r + 1 == h) begin
      push_pixel(r, c, cur, 1'b0);
      n++;
    end
    if (n > 0) pending_pixels[$].last = 1'b1;
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endfunction

  function void check_result(logic [55:0] data, logic rep, logic last);
    out_pixel_t o;
    logic [23:0] got_px;
    got_px = {data[34:27], data[42:35], data[50:43]};
    checked++;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result row %0d col %0d", data[15:0], data[26:16]);
      return;
    end
    o = pending_pixels.pop_front();
    if (rep) replaced_seen++;
    if (o.row !== data[15:0] || o.col !== data[26:16] || o.px !== got_px ||
        o.rep !== rep || o.last !== last || data[55:51] !== '0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: expected r%0d c%0d px %h rep %b last %b, got r%0d c%0d px %h rep %b last %b",
                 o.row, o.col, o.px, o.rep, o.last,
                 data[15:0], data[26:16], got_px, rep, last);
    end
  endfunction
endclass

module tb;
  import orpd_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;  // red, green, blue
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [55:0]         m_axis_tdata;       // row, col, red, green, blue, zero fill
  logic                m_axis_tuser;       // was_replaced
  logic                m_axis_tlast;

  denoise_scoreboard pixel_sb = new();
  int send_idle_pct = 31;
  int recv_idle_pct = 53;
  int items_sent = 0;
  int base_level;

  outlier_replace_denoise_3x3 DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("outlier_replace_denoise_3x3 verification failed");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      pixel_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Writes the width register, then the height register.
  task automatic write_frame(input logic [15:0] w, input logic [15:0] h);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegFrameWidth;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= RegFrameHeight;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pixel_sb.set_reg(RegFrameWidth, w);
    pixel_sb.set_reg(RegFrameHeight, h);
  endtask

  // Waits until every predicted pixel is out and the pipeline has emptied.
  task automatic drain();
    while (pixel_sb.pending() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  // pix is {red, green, blue}; the bus carries red in the lowest byte.
  task automatic send_pixel(input logic [23:0] pix);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pix[7:0], pix[15:8], pix[23:16]};
    do @(posedge clk_i); while (!s_axis_tready);
    pixel_sb.note_pixel(pix);
    items_sent++;
  endtask

  function automatic logic [7:0] near_base();
    int v;
    v = base_level + $urandom_range(16) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Mostly smooth content so the outlier test sees both outcomes.
  function automatic logic [23:0] random_pixel();
    int k;
    k = $urandom_range(99);
    if (k < 70) return {near_base(), near_base(), near_base()};
    if (k < 85) return {8'($urandom_range(1)*255), 8'($urandom_range(255)),
                        8'($urandom_range(1)*255)};
    return 24'($urandom);
  endfunction

  task automatic run_phase(input int w, input int h, input int n_items, input int hold_at);
    write_frame(16'(w), 16'(h));
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) base_level = $urandom_range(255);
      if (i == hold_at) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pixel_sb.pending() != 0) @(posedge clk_i);
      end
      send_pixel(random_pixel());
    end
    s_axis_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    logic [23:0] pix;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed 5x4 frame: flat gray with a white and a black outlier, a
    // colored pixel and extreme values in the corners.
    write_frame(16'd5, 16'd4);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 5; c++) begin
        pix = 24'h646464;
        if (r == 1 && c == 1) pix = 24'hFFFFFF;
        if (r == 2 && c == 2) pix = 24'h000000;
        if (r == 1 && c == 3) pix = 24'hFF00FF;
        if (r == 0 && c == 0) pix = 24'hFFFFFF;
        if (r == 3 && c == 4) pix = 24'h000000;
        send_pixel(pix);
      end
    end
    s_axis_tvalid <= 1'b0;
    drain();

    // Width above the line length saturates; zero sizes act as one.
    run_phase(4095, 1, 40, -1);
    run_phase(0, 0, 24, -1);
    run_phase(2, 7, 28, -1);
    run_phase(7, 2, 28, -1);
    send_idle_pct = 53;
    recv_idle_pct = 31;
    run_phase(3, 3, 45, -1);
    run_phase(16, 5, 80, 40);
    // Tallest frame, left unfinished; height one then restarts the row count.
    run_phase(1, 65535, 20, -1);
    run_phase(1, 1, 4, -1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(9, 5, 90, -1);
    run_phase(2048, 3, 64, -1);
    run_phase(4, 4, 32, -1);

    drain();
    $display("Sent %0d pixels over frames from 1x1 to 2048 wide, with and without stalls.",
             items_sent);
    $display("Checked %0d output pixels, %0d of them replaced by the neighbor mean.",
             pixel_sb.checked, pixel_sb.replaced_seen);
    if (pixel_sb.mismatches == 0 && pixel_sb.pending() == 0) begin
      $display("outlier_replace_denoise_3x3 verification clean");
    end else begin
      $display("%0d mismatches, %0d pixels missing", pixel_sb.mismatches, pixel_sb.pending());
      $display("outlier_replace_denoise_3x3 verification failed");
    end
    $finish;
  end
endmodule
